### hdl/prq_pkg.sv
package prq_pkg;

  localparam int QUEUE_BYTES_DEF  = 8192;
  localparam int MAX_PAYLOAD_DEF  = 1024;
  localparam int HEADER_BYTES_DEF = 12;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_READ = 2'd2,
    KIND_SENT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_ORDER = 2'd1,
    ERR_SIZE  = 2'd2,
    ERR_EMPTY = 2'd3
  } err_t;

endpackage

### hdl/prq_in_if.sv
interface prq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [10:0] pkt_size;
  logic [31:0] ip_addr;
  logic [15:0] port_num;
  logic [7:0]  data_byte;
  logic [9:0]  read_offset;
  logic        sent_ok;

  modport source (output valid, kind, pkt_size, ip_addr, port_num, data_byte,
                  read_offset, sent_ok, input ready);
  modport sink (input valid, kind, pkt_size, ip_addr, port_num, data_byte,
                read_offset, sent_ok, output ready);
endinterface

### hdl/prq_out_if.sv
interface prq_out_if;
  logic        valid;
  logic        ready;
  logic        queue_empty;
  logic        dropped_old;
  logic [31:0] head_ip;
  logic [15:0] head_port;
  logic [10:0] head_size;
  logic [7:0]  head_byte;
  logic [1:0]  error_code;

  modport source (output valid, queue_empty, dropped_old, head_ip, head_port,
                  head_size, head_byte, error_code, input ready);
  modport sink (input valid, queue_empty, dropped_old, head_ip, head_port,
                head_size, head_byte, error_code, output ready);
endinterface

### hdl/prq_ram.sv
module prq_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/packet_ring_queue_drop_oldest_top.sv
// Steps: a payload beat or a rejected item goes straight to S_DONE; a read fetches the
//   head header (S_RDH), then one payload byte (S_RDB, S_RDB2; an offset past the size
//   skips S_RDB2); a complete pops the head (S_RDH, S_POP, S_GAP) only if sent; an
//   enqueue passes S_WRAP (and S_GAP on a wrap), drops oldest records (S_FIT, S_RDH,
//   S_POP, S_GAP) until it fits, then writes the header (S_HDR). The byte memory takes
//   at most one byte read and one written a cycle; one item at a time, rsp.ready can stall.
// Reset: synchronous; clears pointers and counters; the ring memory is not cleared
//   and needs no sweep.
module packet_ring_queue_drop_oldest_top
  import prq_pkg::*;
#(
  parameter int QUEUE_BYTES  = QUEUE_BYTES_DEF,
  parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input logic     clk,
  input logic     rst,
  prq_in_if.sink  req,
  prq_out_if.source rsp
);

  // address, position (holds QUEUE_BYTES itself), wide arithmetic and counter widths
  localparam int AW = $clog2(QUEUE_BYTES);
  localparam int PW = $clog2(QUEUE_BYTES + 1);
  localparam int EW = PW + 17;
  localparam int CW = $clog2((HEADER_BYTES > 8 ? HEADER_BYTES : 8) + 1);

  localparam logic [EW-1:0] QE  = EW'(QUEUE_BYTES);
  localparam logic [EW-1:0] HBE = EW'(HEADER_BYTES);
  localparam logic [EW-1:0] MPE = EW'(MAX_PAYLOAD);
  localparam logic [CW-1:0] HB_LAST = CW'(HEADER_BYTES - 1);
  localparam logic [CW-1:0] LIM_HDR = CW'(8);
  localparam logic [CW-1:0] LIM_POP = CW'(2);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_WRAP = 10'b0000000010,
    S_GAP  = 10'b0000000100,
    S_FIT  = 10'b0000001000,
    S_RDH  = 10'b0000010000,
    S_POP  = 10'b0000100000,
    S_HDR  = 10'b0001000000,
    S_RDB  = 10'b0010000000,
    S_RDB2 = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state;

  // queue pointers; used counts the wrap gap as occupied
  logic [PW-1:0] head, tail, endm, used;
  logic [AW-1:0] fill;
  logic [10:0]   left;
  logic [CW-1:0] cnt;

  // held item
  kind_t       kind_q;
  logic [10:0] size_q;
  logic [31:0] ip_q;
  logic [15:0] port_q;
  logic [9:0]  off_q;

  // header bytes read back from the head record
  logic [7:0] hdr [8];

  // result being built, and the output register
  logic        res_drop;
  logic [31:0] res_ip;
  logic [15:0] res_port;
  logic [10:0] res_size;
  logic [7:0]  res_byte;
  err_t        res_err;

  logic        out_valid;
  logic        out_empty, out_drop;
  logic [31:0] out_ip;
  logic [15:0] out_port;
  logic [10:0] out_size;
  logic [7:0]  out_byte;
  err_t        out_err;

  // memory port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  prq_ram #(.DEPTH(QUEUE_BYTES), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // fold a sum below twice the ring size back into the ring
  function automatic logic [AW-1:0] ring_addr(input logic [EW-1:0] a);
    logic [EW-1:0] r;
    r = (a >= QE) ? a - QE : a;
    return r[AW-1:0];
  endfunction

  logic          accept;
  logic [EW-1:0] head_e, tail_e, endm_e, used_e;
  logic [EW-1:0] ps_req, ps_rec, right, wrap_g, wrap_used;
  logic          wrap_hit, wrap_drop;
  logic          gap_hit;
  logic [EW-1:0] gap_g, gap_used;
  logic [15:0]   hsize;
  logic [EW-1:0] pop_ps, pop_hn, tail_n, fill_n;
  logic          fit_need;
  logic [CW-1:0] rd_lim;
  logic [7:0]    hdr_wbyte;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign head_e = EW'(head);
  assign tail_e = EW'(tail);
  assign endm_e = EW'(endm);
  assign used_e = EW'(used);

  always_comb begin
    ps_req = EW'(req.pkt_size) + HBE;
    ps_rec = EW'(size_q) + HBE;

    // record would cross the ring end: drop what lies beyond the tail, mark the gap
    right     = QE - tail_e;
    wrap_hit  = ps_rec > right;
    wrap_drop = (used != '0) && (head >= tail);
    wrap_g    = QE - head_e;
    if (wrap_drop) begin
      wrap_used = (wrap_g <= used_e) ? used_e - wrap_g : '0;
    end else begin
      wrap_used = used_e;
    end

    // pass the head over the wrap gap
    gap_hit = (used != '0) && (head == endm);
    gap_g   = QE - endm_e;
    if (gap_hit) begin
      gap_used = (gap_g <= used_e) ? used_e - gap_g : '0;
    end else begin
      gap_used = used_e;
    end

    hsize  = {hdr[1], hdr[0]};
    pop_ps = EW'(hsize) + HBE;
    pop_hn = head_e + pop_ps;

    fit_need = (used != '0) && (used_e > QE - ps_rec);
    tail_n   = tail_e + ps_rec;
    fill_n   = tail_e + HBE;
    rd_lim   = (kind_q == KIND_READ) ? LIM_HDR : LIM_POP;
  end

  // header layout: size, address, port little endian, rest zero
  always_comb begin
    case (cnt)
      CW'(0):  hdr_wbyte = size_q[7:0];
      CW'(1):  hdr_wbyte = {5'd0, size_q[10:8]};
      CW'(2):  hdr_wbyte = ip_q[7:0];
      CW'(3):  hdr_wbyte = ip_q[15:8];
      CW'(4):  hdr_wbyte = ip_q[23:16];
      CW'(5):  hdr_wbyte = ip_q[31:24];
      CW'(6):  hdr_wbyte = port_q[7:0];
      CW'(7):  hdr_wbyte = port_q[15:8];
      default: hdr_wbyte = 8'd0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail[AW-1:0];
    ram_wdata = hdr_wbyte;
    ram_re    = 1'b0;
    ram_raddr = ring_addr(head_e + EW'(cnt));
    unique case (state)
      S_IDLE: begin
        ram_we    = accept && (kind_t'(req.kind) == KIND_DATA) && (left != '0);
        ram_waddr = fill;
        ram_wdata = req.data_byte;
      end
      S_HDR: begin
        ram_we    = 1'b1;
        ram_waddr = ring_addr(tail_e + EW'(cnt));
      end
      S_RDH: begin
        ram_re = (cnt < rd_lim);
      end
      S_RDB: begin
        ram_re    = EW'(off_q) < EW'(hsize);
        ram_raddr = ring_addr(head_e + HBE + EW'(off_q));
      end
      S_WRAP, S_GAP, S_FIT, S_POP, S_RDB2, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // payload regs: held item and header bytes read back
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind_t'(req.kind);
      size_q <= req.pkt_size;
      ip_q   <= req.ip_addr;
      port_q <= req.port_num;
      off_q  <= req.read_offset;
    end
    if (state == S_RDH && cnt != '0) begin
      hdr[3'(cnt - CW'(1))] <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      endm      <= PW'(QUEUE_BYTES);
      used      <= '0;
      fill      <= '0;
      left      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_drop <= 1'b0;
            res_ip   <= '0;
            res_port <= '0;
            res_size <= '0;
            res_byte <= '0;
            res_err  <= ERR_OK;
            cnt      <= '0;
            state    <= S_DONE;
            unique case (kind_t'(req.kind))
              KIND_ENQ: begin
                if (left != '0) begin
                  res_err <= ERR_ORDER;
                end else if (EW'(req.pkt_size) > MPE || ps_req > QE) begin
                  res_err <= ERR_SIZE;
                end else begin
                  state <= S_WRAP;
                end
              end
              KIND_DATA: begin
                if (left == '0) begin
                  res_err <= ERR_ORDER;
                end else begin
                  fill <= ring_addr(EW'(fill) + EW'(1));
                  left <= left - 11'd1;
                end
              end
              KIND_READ, KIND_SENT: begin
                if (left != '0) begin
                  res_err <= ERR_ORDER;
                end else if (used == '0) begin
                  res_err <= ERR_EMPTY;
                end else if (kind_t'(req.kind) == KIND_READ || req.sent_ok) begin
                  state <= S_RDH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_WRAP: begin
          if (wrap_hit) begin
            if (wrap_drop) begin
              res_drop <= 1'b1;
            end
            head  <= wrap_drop ? '0 : head;
            endm  <= tail;
            used  <= PW'(wrap_used + right);
            tail  <= '0;
            state <= S_GAP;
          end else begin
            state <= S_FIT;
          end
        end
        S_GAP: begin
          if (gap_hit) begin
            head <= '0;
            endm <= PW'(QUEUE_BYTES);
          end
          used <= PW'(gap_used);
          if (kind_q == KIND_ENQ) begin
            state <= S_FIT;
          end else begin
            // queue drained by the pop: rewind all pointers
            if (gap_used == '0) begin
              head <= '0;
              tail <= '0;
              endm <= PW'(QUEUE_BYTES);
            end
            state <= S_DONE;
          end
        end
        S_FIT: begin
          cnt <= '0;
          if (fit_need) begin
            res_drop <= 1'b1;
            state    <= S_RDH;
          end else begin
            state <= S_HDR;
          end
        end
        S_RDH: begin
          if (cnt == rd_lim) begin
            state <= (kind_q == KIND_READ) ? S_RDB : S_POP;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_POP: begin
          head  <= (pop_hn >= QE) ? '0 : PW'(pop_hn);
          used  <= (pop_ps <= used_e) ? PW'(used_e - pop_ps) : '0;
          state <= S_GAP;
        end
        S_HDR: begin
          if (cnt == HB_LAST) begin
            fill  <= ring_addr(fill_n);
            left  <= size_q;
            tail  <= (tail_n >= QE) ? '0 : PW'(tail_n);
            used  <= PW'(used_e + ps_rec);
            state <= S_DONE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_RDB: begin
          res_size <= hsize[10:0];
          res_ip   <= {hdr[5], hdr[4], hdr[3], hdr[2]};
          res_port <= {hdr[7], hdr[6]};
          if (EW'(off_q) >= EW'(hsize)) begin
            res_err <= ERR_EMPTY;
            state   <= S_DONE;
          end else begin
            state <= S_RDB2;
          end
        end
        S_RDB2: begin
          res_byte <= ram_rdata;
          state    <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_empty <= (used == '0);
      out_drop  <= res_drop;
      out_ip    <= res_ip;
      out_port  <= res_port;
      out_size  <= res_size;
      out_byte  <= res_byte;
      out_err   <= res_err;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.queue_empty = out_empty;
  assign rsp.dropped_old = out_drop;
  assign rsp.head_ip     = out_ip;
  assign rsp.head_port   = out_port;
  assign rsp.head_size   = out_size;
  assign rsp.head_byte   = out_byte;
  assign rsp.error_code  = out_err;

endmodule

### hdl/prq_check.sv
module prq_check
  import prq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_drop,
  input logic [31:0] rsp_ip,
  input logic [10:0] rsp_size,
  input logic [7:0]  rsp_byte,
  input logic [1:0]  rsp_err
);

  // no beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result beat right after reset");

  // stalled beat stays valid with error code and byte held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_err) && $stable(rsp_byte))
    else $error("stalled result beat changed");

  // drop only on an enqueue that went through
  a_drop_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_drop |-> rsp_err == ERR_OK)
    else $error("drop reported with an error");

  // payload byte only on a good read
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_err != ERR_OK |-> rsp_byte == 8'd0)
    else $error("payload byte on a failed item");

  // rejected items report no header
  a_no_hdr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_err == ERR_ORDER || rsp_err == ERR_SIZE)
      |-> rsp_ip == 32'd0 && rsp_size == 11'd0)
    else $error("header fields on a rejected item");

endmodule

bind packet_ring_queue_drop_oldest_top prq_check u_prq_check (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_drop  (rsp.dropped_old),
  .rsp_ip    (rsp.head_ip),
  .rsp_size  (rsp.head_size),
  .rsp_byte  (rsp.head_byte),
  .rsp_err   (rsp.error_code)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import prq_pkg::*;

  localparam int QB = QUEUE_BYTES_DEF;
  localparam int MP = MAX_PAYLOAD_DEF;
  localparam int HB = HEADER_BYTES_DEF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] pkt_size;
    logic [31:0] ip_addr;
    logic [15:0] port_num;
    logic [7:0]  data_byte;
    logic [9:0]  read_offset;
    logic        sent_ok;
  } cmd_t;

  typedef struct packed {
    logic        queue_empty;
    logic        dropped_old;
    logic [31:0] head_ip;
    logic [15:0] head_port;
    logic [10:0] head_size;
    logic [7:0]  head_byte;
    logic [1:0]  error_code;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  prq_in_if  req_if();
  prq_out_if rsp_if();

  packet_ring_queue_drop_oldest_top u_top (
    .clk(clk), .rst(rst), .req(req_if.sink), .rsp(rsp_if.source)
  );

  always #2 clk = ~clk;

  // Shadow copy of the ring and its pointers; unwritten bytes are never read.
  logic [7:0] ring_mem [QB];
  int unsigned hd = 0, tl = 0, endm = QB, used = 0, fillp = 0, left = 0;

  cmd_t cmd_q[$];
  rsp_t want_q[$];
  int   errors = 0;
  int   n_drops = 0;
  int   n_reads = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  bit   hold_send = 1'b0;
  int   phase = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
  endtask

  function automatic int unsigned rec_len(input int unsigned p);
    return 32'({ring_mem[(p + 1) % QB], ring_mem[p % QB]});
  endfunction

  function automatic void pass_gap();
    int unsigned g;
    if (used != 0 && hd == endm) begin
      g = QB - endm;
      used = (g <= used) ? used - g : 0;
      hd = 0;
      endm = QB;
    end
  endfunction

  function automatic void drop_head();
    int unsigned ps;
    ps = rec_len(hd) + HB;
    hd += ps;
    if (hd >= QB) hd = 0;
    used = (ps <= used) ? used - ps : 0;
    pass_gap();
  endfunction

  function automatic rsp_t predict_queue(input cmd_t c);
    rsp_t r;
    int unsigned sz, ps, right, g, off, hsz;
    r = '0;
    r.error_code = ERR_OK;
    case (kind_t'(c.kind))
      KIND_ENQ: begin
        sz = 32'(c.pkt_size);
        ps = sz + HB;
        if (left != 0) r.error_code = ERR_ORDER;
        else if (sz > MP || ps > QB) r.error_code = ERR_SIZE;
        else begin
          right = QB - tl;
          if (ps > right) begin
            if (used != 0 && hd >= tl) begin
              g = QB - hd;
              used = (g <= used) ? used - g : 0;
              hd = 0;
              endm = QB;
              r.dropped_old = 1'b1;
            end
            endm = tl;
            used += right;
            tl = 0;
            pass_gap();
          end
          while (used != 0 && used > QB - ps) begin
            drop_head();
            r.dropped_old = 1'b1;
          end
          ring_mem[tl] = sz[7:0];
          ring_mem[(tl + 1) % QB] = sz[15:8];
          for (int i = 0; i < 4; i++) ring_mem[(tl + 2 + i) % QB] = c.ip_addr[8*i +: 8];
          ring_mem[(tl + 6) % QB] = c.port_num[7:0];
          ring_mem[(tl + 7) % QB] = c.port_num[15:8];
          for (int i = 8; i < HB; i++) ring_mem[(tl + i) % QB] = 8'h00;
          fillp = tl + HB;
          left = sz;
          tl += ps;
          if (tl >= QB) tl = 0;
          used += ps;
        end
      end
      KIND_DATA: begin
        if (left == 0) r.error_code = ERR_ORDER;
        else begin
          ring_mem[fillp % QB] = c.data_byte;
          fillp = (fillp + 1) % QB;
          left--;
        end
      end
      default: begin
        if (left != 0) r.error_code = ERR_ORDER;
        else if (used == 0) r.error_code = ERR_EMPTY;
        else if (kind_t'(c.kind) == KIND_READ) begin
          off = 32'(c.read_offset);
          hsz = rec_len(hd);
          r.head_size = 11'(hsz);
          for (int i = 0; i < 4; i++) r.head_ip[8*i +: 8] = ring_mem[(hd + 2 + i) % QB];
          r.head_port = {ring_mem[(hd + 7) % QB], ring_mem[(hd + 6) % QB]};
          if (off >= hsz) r.error_code = ERR_EMPTY;
          else r.head_byte = ring_mem[(hd + HB + off) % QB];
        end else if (c.sent_ok) begin
          drop_head();
          if (used == 0) begin
            hd = 0;
            tl = 0;
            endm = QB;
          end
        end
      end
    endcase
    r.queue_empty = (used == 0);
    return r;
  endfunction

  // Driver: present the next pending item, hold it until accepted.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      {req_if.kind, req_if.pkt_size, req_if.ip_addr, req_if.port_num, req_if.data_byte,
       req_if.read_offset, req_if.sent_ok} <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        want_q.push_back(predict_queue(cmd_q.pop_front()));
      end
      if (!(req_if.valid && !req_if.ready)) begin
        // Pick the next beat only once the current one is gone.
        if (cmd_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          req_if.valid <= 1'b1;
          {req_if.kind, req_if.pkt_size, req_if.ip_addr, req_if.port_num, req_if.data_byte,
           req_if.read_offset, req_if.sent_ok} <= cmd_q[0];
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every accepted result against the oldest prediction.
  always @(posedge clk) begin
    rsp_t got, exp;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall);
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.queue_empty, rsp_if.dropped_old, rsp_if.head_ip, rsp_if.head_port,
               rsp_if.head_size, rsp_if.head_byte, rsp_if.error_code};
        if (want_q.size() == 0) begin
          report("unexpected result", 64'(got.head_ip), 64'd0);
        end else begin
          exp = want_q.pop_front();
          if (exp.dropped_old) n_drops++;
          if (exp.head_size != 0) n_reads++;
          if (got.queue_empty !== exp.queue_empty)
            report("queue_empty", 64'(got.queue_empty), 64'(exp.queue_empty));
          if (got.dropped_old !== exp.dropped_old)
            report("dropped_old", 64'(got.dropped_old), 64'(exp.dropped_old));
          if (got.head_ip !== exp.head_ip)
            report("head_ip", 64'(got.head_ip), 64'(exp.head_ip));
          if (got.head_port !== exp.head_port)
            report("head_port", 64'(got.head_port), 64'(exp.head_port));
          if (got.head_size !== exp.head_size)
            report("head_size", 64'(got.head_size), 64'(exp.head_size));
          if (got.head_byte !== exp.head_byte)
            report("head_byte", 64'(got.head_byte), 64'(exp.head_byte));
          if (got.error_code !== exp.error_code)
            report("error_code", 64'(got.error_code), 64'(exp.error_code));
        end
      end
    end
  end

  // Stimulus builders.
  function automatic cmd_t mk(input kind_t k);
    cmd_t c;
    c = '0;
    c.kind = k;
    c.ip_addr = $urandom();
    c.port_num = 16'($urandom());
    c.data_byte = 8'($urandom());
    c.read_offset = 10'($urandom());
    c.sent_ok = 1'($urandom());
    c.pkt_size = 11'($urandom());
    return c;
  endfunction

  task automatic add_packet(input int sz, input bit full);
    cmd_t c;
    int n;
    c = mk(KIND_ENQ);
    c.pkt_size = 11'(sz);
    cmd_q.push_back(c);
    if (sz <= MP) begin
      n = full ? sz : int'($urandom_range(sz));
      for (int i = 0; i < n; i++) cmd_q.push_back(mk(KIND_DATA));
    end
  endtask

  task automatic finish_open();
    // Pad any short payload so later reads see written bytes.
    int sz;
    cmd_t c;
    sz = 0;
    for (int i = cmd_q.size() - 1; i >= 0; i--) begin
      if (cmd_q[i].kind == KIND_ENQ && cmd_q[i].pkt_size <= MP) begin
        sz = int'(cmd_q[i].pkt_size);
        for (int j = i + 1; j < cmd_q.size(); j++) if (cmd_q[j].kind == KIND_DATA) sz--;
        break;
      end
    end
    for (int i = 0; i < sz; i++) cmd_q.push_back(mk(KIND_DATA));
  endtask

  task automatic wait_drain();
    while (cmd_q.size() != 0 || req_if.valid || want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int pick_size();
    case ($urandom_range(9))
      0: return 0;
      1: return int'($urandom_range(48));
      default: return int'($urandom_range(16));
    endcase
  endfunction

  task automatic random_burst(input int items);
    cmd_t c;
    int target;
    target = cmd_q.size() + items;
    while (cmd_q.size() < target) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: add_packet(pick_size(), 1'b1);
        7: begin
          // Broken sequence: possibly short payload, then an item (out of order if short), then pad.
          add_packet(int'($urandom_range(1, 16)), 1'b0);
          c = mk(kind_t'($urandom_range(3)));
          if (c.kind == KIND_DATA) c.kind = KIND_READ;
          c.pkt_size = 11'($urandom_range(MP));
          cmd_q.push_back(c);
          finish_open();
        end
        8: begin
          c = mk(KIND_ENQ);
          c.pkt_size = 11'($urandom_range(MP + 1, 2047));
          cmd_q.push_back(c);
        end
        9: cmd_q.push_back(mk(KIND_DATA));
        10, 11, 12, 13: begin
          c = mk(KIND_READ);
          if ($urandom_range(1)) c.read_offset = 10'($urandom_range(15));
          cmd_q.push_back(c);
        end
        default: cmd_q.push_back(mk(KIND_SENT));
      endcase
    end
    finish_open();
  endtask

  initial begin
    cmd_t c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-queue read and complete, stray payload, oversize, extremes.
    cmd_q.push_back(mk(KIND_READ));
    c = mk(KIND_SENT); c.sent_ok = 1'b1; cmd_q.push_back(c);
    cmd_q.push_back(mk(KIND_DATA));
    c = mk(KIND_ENQ); c.pkt_size = 11'h7ff; cmd_q.push_back(c);
    c = mk(KIND_ENQ); c.pkt_size = 11'(MP + 1); cmd_q.push_back(c);
    c = mk(KIND_ENQ); c.pkt_size = 3; c.ip_addr = '1; c.port_num = '1; cmd_q.push_back(c);
    c = mk(KIND_ENQ); cmd_q.push_back(c);                    // enqueue while payload pending
    c = mk(KIND_READ); cmd_q.push_back(c);                   // read while pending
    c = mk(KIND_SENT); cmd_q.push_back(c);                   // complete while pending
    c = mk(KIND_DATA); c.data_byte = 8'hff; cmd_q.push_back(c);
    c = mk(KIND_DATA); c.data_byte = 8'h00; cmd_q.push_back(c);
    c = mk(KIND_DATA); cmd_q.push_back(c);
    c = mk(KIND_READ); c.read_offset = 0; cmd_q.push_back(c);
    c = mk(KIND_READ); c.read_offset = 2; cmd_q.push_back(c);
    c = mk(KIND_READ); c.read_offset = 3; cmd_q.push_back(c);   // offset at size
    c = mk(KIND_READ); c.read_offset = '1; cmd_q.push_back(c);
    c = mk(KIND_SENT); c.sent_ok = 1'b0; cmd_q.push_back(c);
    c = mk(KIND_ENQ); c.pkt_size = 0; c.ip_addr = '0; c.port_num = '0; cmd_q.push_back(c);
    c = mk(KIND_SENT); c.sent_ok = 1'b1; cmd_q.push_back(c);
    c = mk(KIND_READ); c.read_offset = 0; cmd_q.push_back(c);   // zero-length head
    c = mk(KIND_SENT); c.sent_ok = 1'b1; cmd_q.push_back(c);
    c = mk(KIND_SENT); c.sent_ok = 1'b1; cmd_q.push_back(c);   // complete on an empty queue
    wait_drain();

    // A mid-size record read at its last byte.
    add_packet(40, 1'b1);
    c = mk(KIND_READ); c.read_offset = 39; cmd_q.push_back(c);

    // Random phases with different idle mixes.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 87; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      random_burst(phase == 0 ? 220 : 120);
      if (phase == 1) begin
        // Hold the sender until every outstanding result has come back.
        while (cmd_q.size() > 100) @(posedge clk);
        @(posedge clk);
        hold_send = 1'b1;
        while (req_if.valid || want_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        hold_send = 1'b0;
      end
      wait_drain();
    end
    repeat (40) @(posedge clk);
    $display("run covered four idle mixes; %0d drop-oldest enqueues, %0d head reads with data",
             n_drops, n_reads);
    if (errors == 0 && want_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout waiting for results");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
